@@ sv/pidst_pkg.sv @@
// Package for the PID step block with settle and timeout supervision.
// Holds the register map, the configuration and update structs and helpers.
// No dependencies.
package pidst_pkg;

    localparam int ERR_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 15;
    localparam int TIME_W   = 16;
    localparam int TICK_W   = 8;
    localparam int TIMER_W  = 17;
    localparam int SUM_W    = 24;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int DRIVE_W  = 32;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [CFG_AW-1:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_I          = 3'd1,
        REG_GAIN_D          = 3'd2,
        REG_SETTLE_BAND     = 3'd3,
        REG_SETTLE_DURATION = 3'd4,
        REG_TIMEOUT_LIMIT   = 3'd5,
        REG_WINDUP_LIMIT    = 3'd6,
        REG_TICK_MS         = 3'd7
    } reg_idx_t;

    localparam logic [GAIN_W-1:0] GAIN_P_RST          = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_I_RST          = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST          = 16'd0;
    localparam logic [BAND_W-1:0] SETTLE_BAND_RST     = 15'd256;
    localparam logic [TIME_W-1:0] SETTLE_DURATION_RST = 16'd300;
    localparam logic [TIME_W-1:0] TIMEOUT_LIMIT_RST   = 16'd5000;
    localparam logic [BAND_W-1:0] WINDUP_LIMIT_RST    = 15'd32767;
    localparam logic [TICK_W-1:0] TICK_MS_RST         = 8'd10;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [BAND_W-1:0] settle_band;
        logic [TIME_W-1:0] settle_duration;
        logic [TIME_W-1:0] timeout_limit;
        logic [BAND_W-1:0] windup_limit;
        logic [TICK_W-1:0] tick_ms;
    } pidst_cfg_t;

    // Per-item result of the state update, fed to the multiply stage
    typedef struct packed {
        logic                      settled;
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   error_sum;
        logic signed [DERIV_W-1:0] deriv;
    } pidst_upd_t;

    function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t,
                                                     input logic [TICK_W-1:0] d);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + {{(TIMER_W+1-TICK_W){1'b0}}, d};
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

endpackage

@@ sv/pid_step_with_settle_timeout_core.sv @@
// PID step with settle and timeout supervision: top level.
// Usage:
//   s_ channel carries one signed Q8.8 error sample per item in s_tdata.
//   m_ channel returns one item per input: signed Q16.16 drive in m_tdata,
//   settled flag in m_tuser (drive is zero whenever settled is high).
//   Gains, bands and timer limits are written through cfg_wr_en / cfg_addr /
//   cfg_wr_data while no item is in flight.
// Timing:
//   Four register stages: input, state update, products, output. A result
//   appears on m_ once its item has passed all four. One item per cycle is
//   sustained while m_tready is high; the state update feeds the next item directly.
//   Every stage holds while the one after it is full and stalled, so s_tready
//   stays high as long as a bubble remains anywhere in the pipeline.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline, clears timers,
//   integral and previous error, and loads the default register values.
// Depends on pidst_pkg and pidst_state.
module pid_step_with_settle_timeout_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [pidst_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [pidst_pkg::CFG_DW-1:0]    cfg_wr_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] error_sample
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [31:0] drive
    output logic                            m_tuser    // [0] settled
);
    import pidst_pkg::*;

    localparam int PP_W  = GAIN_W + 1 + ERR_W;     // gain_p * err
    localparam int PI_W  = GAIN_W + 1 + SUM_W;     // gain_i * error_sum
    localparam int PD_W  = GAIN_W + 1 + DERIV_W;   // gain_d * deriv
    localparam int ACC_W = PI_W + 2;

    pidst_cfg_t cfg_reg;

    logic                    v1_reg, v2_reg, v3_reg, vo_reg;
    logic                    rdy1, rdy2, rdy3, rdyo;
    logic signed [ERR_W-1:0] err_reg;
    pidst_upd_t              upd;
    pidst_upd_t              upd_reg;
    logic signed [PP_W-1:0]  prod_p_reg, prod_p_next;
    logic signed [PI_W-1:0]  prod_i_reg, prod_i_next;
    logic signed [PD_W-1:0]  prod_d_reg, prod_d_next;
    logic                    s3_settled_reg;
    logic signed [ACC_W-1:0] acc;
    logic [DRIVE_W-1:0]      drive_next, drive_reg;
    logic                    settled_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p          <= GAIN_P_RST;
            cfg_reg.gain_i          <= GAIN_I_RST;
            cfg_reg.gain_d          <= GAIN_D_RST;
            cfg_reg.settle_band     <= SETTLE_BAND_RST;
            cfg_reg.settle_duration <= SETTLE_DURATION_RST;
            cfg_reg.timeout_limit   <= TIMEOUT_LIMIT_RST;
            cfg_reg.windup_limit    <= WINDUP_LIMIT_RST;
            cfg_reg.tick_ms         <= TICK_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_GAIN_P:          cfg_reg.gain_p          <= cfg_wr_data;
                REG_GAIN_I:          cfg_reg.gain_i          <= cfg_wr_data;
                REG_GAIN_D:          cfg_reg.gain_d          <= cfg_wr_data;
                REG_SETTLE_BAND:     cfg_reg.settle_band     <= cfg_wr_data[BAND_W-1:0];
                REG_SETTLE_DURATION: cfg_reg.settle_duration <= cfg_wr_data;
                REG_TIMEOUT_LIMIT:   cfg_reg.timeout_limit   <= cfg_wr_data;
                REG_WINDUP_LIMIT:    cfg_reg.windup_limit    <= cfg_wr_data[BAND_W-1:0];
                REG_TICK_MS:         cfg_reg.tick_ms         <= cfg_wr_data[TICK_W-1:0];
                default:             ;
            endcase
        end
    end

    // Per-stage ready: a stage may load when empty or when it drains this cycle
    assign rdyo     = !vo_reg || m_tready;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    pidst_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .adv     (v1_reg && rdy2),
        .err     (err_reg),
        .upd     (upd)
    );

    always_comb begin
        prod_p_next = $signed({1'b0, cfg_reg.gain_p}) * upd_reg.err;
        prod_i_next = $signed({1'b0, cfg_reg.gain_i}) * upd_reg.error_sum;
        prod_d_next = $signed({1'b0, cfg_reg.gain_d}) * upd_reg.deriv;

        acc = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
        // Saturate to 32 bits; force zero once settled
        if (s3_settled_reg) begin
            drive_next = '0;
        end else if (acc[ACC_W-1:DRIVE_W-1] == '0 ||
                     acc[ACC_W-1:DRIVE_W-1] == '1) begin
            drive_next = acc[DRIVE_W-1:0];
        end else begin
            drive_next = acc[ACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                      : {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            err_reg <= $signed(s_tdata[ERR_W-1:0]);
        end
        if (rdy2 && v1_reg) begin
            upd_reg <= upd;
        end
        if (rdy3 && v2_reg) begin
            prod_p_reg     <= prod_p_next;
            prod_i_reg     <= prod_i_next;
            prod_d_reg     <= prod_d_next;
            s3_settled_reg <= upd_reg.settled;
        end
        if (rdyo && v3_reg) begin
            drive_reg   <= drive_next;
            settled_reg <= s3_settled_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = settled_reg;

`ifndef NO_ASSERTIONS
    // A settled result carries zero drive
    a_settled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("settled result with nonzero drive");

    // Stage 3 holds its item while the output stage is stalled
    a_s3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdyo) |=> (v3_reg && $stable(prod_i_reg)))
        else $error("stage 3 lost an item under stall");

    // An empty pipeline always takes the next item
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg && !v3_reg && !vo_reg) |-> s_tready)
        else $error("empty pipeline refused input");

    // An item in stage 1 moves on when stage 2 frees up
    a_s1_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("stage 1 item dropped");
`endif

endmodule

@@ sv/pidst_state.sv @@
// Controller state for the PID step block: timers, integral, previous error.
// Computes the per-item update and commits it when the item advances.
// Depends on pidst_pkg.
module pidst_state (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pidst_pkg::pidst_cfg_t         cfg,
    input  logic                          adv,
    input  logic signed [pidst_pkg::ERR_W-1:0] err,
    output pidst_pkg::pidst_upd_t         upd
);
    import pidst_pkg::*;

    logic [TIMER_W-1:0]      elapsed_ms_reg, elapsed_ms_next;
    logic [TIMER_W-1:0]      settled_ms_reg, settled_ms_next;
    logic signed [SUM_W-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0] last_error_reg;

    logic                    stop;
    logic [ERR_W:0]          err_ext;
    logic [ERR_W:0]          err_mag;
    logic [ERR_W:0]          band_ext;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_sat;
    logic [SUM_W-1:0]        sum_mag;

    always_comb begin
        elapsed_ms_next = timer_add(elapsed_ms_reg, cfg.tick_ms);
        stop = (elapsed_ms_next > {1'b0, cfg.timeout_limit}) ||
               (settled_ms_reg > {1'b0, cfg.settle_duration});

        err_ext  = {err[ERR_W-1], err};
        err_mag  = err_ext[ERR_W] ? (~err_ext + 1'b1) : err_ext;
        band_ext = {{(ERR_W+1-BAND_W){1'b0}}, cfg.settle_band};

        settled_ms_next = (err_mag < band_ext) ? timer_add(settled_ms_reg, cfg.tick_ms)
                                               : settled_ms_reg;

        // Saturating integral
        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg} +
                   {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        sum_mag = sum_sat[SUM_W-1] ? (~sum_sat + 1'b1) : sum_sat;

        // Clear when the integral magnitude is inside the settle band or when the error exceeds the windup limit
        if ((sum_mag < {{(SUM_W-BAND_W){1'b0}}, cfg.settle_band}) ||
            (err_mag > {{(ERR_W+1-BAND_W){1'b0}}, cfg.windup_limit})) begin
            error_sum_next = '0;
        end else begin
            error_sum_next = sum_sat;
        end

        upd.settled   = stop;
        upd.err       = err;
        upd.error_sum = error_sum_next;
        upd.deriv     = $signed(err_ext) - $signed({last_error_reg[ERR_W-1], last_error_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_ms_reg <= '0;
            settled_ms_reg <= '0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else if (adv) begin
            elapsed_ms_reg <= elapsed_ms_next;
            // A settled item touches only the elapsed timer
            if (!stop) begin
                settled_ms_reg <= settled_ms_next;
                error_sum_reg  <= error_sum_next;
                last_error_reg <= err;
            end
        end
    end

endmodule
